@@ rtl/lei_pkg.sv @@
// shared types and constants of the lorenz euler integrator
`timescale 1ns / 1ps
package lei_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned Q_FRAC = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z   = 3'd6;

  // reset values, Q8.24
  localparam logic signed [QW-1:0] RST_STEP_SIZE = 32'sd16777;
  localparam logic signed [QW-1:0] RST_SIGMA     = 32'sd167772160;
  localparam logic signed [QW-1:0] RST_RHO       = 32'sd469762048;
  localparam logic signed [QW-1:0] RST_BETA      = 32'sd44739243;
  localparam logic signed [QW-1:0] RST_START_X   = 32'sd1677722;
  localparam logic signed [QW-1:0] RST_START_Y   = 32'sd0;
  localparam logic signed [QW-1:0] RST_START_Z   = 32'sd0;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_HS   = 10'b00_0000_0010,
    ST_P1   = 10'b00_0000_0100,
    ST_XD   = 10'b00_0000_1000,
    ST_XY   = 10'b00_0001_0000,
    ST_P2   = 10'b00_0010_0000,
    ST_BZ   = 10'b00_0100_0000,
    ST_T2   = 10'b00_1000_0000,
    ST_P3   = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_t;

endpackage

@@ rtl/lei_if.sv @@
// handshake channels of the lorenz euler integrator
`timescale 1ns / 1ps
interface lei_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lei_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

@@ rtl/lorenz_euler_integrator_unit.sv @@
// top level of the lorenz euler integrator: sequencer, shared multiplier and adder
`timescale 1ns / 1ps
// usage
//   in_ch  : one transaction per sample tick; restart=1 reloads x/y/z from the
//            start registers before the step, restart=0 steps from current state
//   out_ch : one transaction per tick carrying the new x, y, z (Q8.24, saturated)
//   cfg_*  : write enable, register index (0..6) and 32-bit data; index 7 ignored;
//            write only while no tick is in flight
// operation
//   ready is high only in idle; a tick then runs through the sequencer states hs,
//   p1, xd, xy, p2, bz, t2, p3 and done, using one shared 32x32 multiplier that
//   takes the seven products one per cycle and one shared saturating adder; no
//   new tick is taken until the sequencer is back in idle
// reset
//   rst_n low (synchronous) loads the register defaults, x=0.1, y=z=0, and
//   empties the output register
// stall
//   the result sits in an output register, so the next tick is accepted while
//   it waits; a finished step holds in its last cycle until the register frees
module lorenz_euler_integrator_unit
  import lei_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lei_in_if.sink               in_ch,
  lei_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [QW-1:0]        cfg_data
);

  state_t state_r, state_nxt;

  q_t step_r, sigma_r, rho_r, beta_r, sx_r, sy_r, sz_r;
  q_t pos_x_r, pos_y_r, pos_z_r;
  q_t prod_r, d1_r, d2_r, nx_r, ny_r;
  q_t ox_r, oy_r, oz_r;
  logic ovalid_r;

  logic in_fire;
  logic out_free;

  // shared multiplier with rounding and saturation
  q_t                mul_a, mul_b, mul_q;
  logic signed [63:0] mul_full, mul_rnd;
  logic signed [39:0] mul_shr;

  // shared saturating adder
  q_t                add_a, add_b, add_q;
  logic              add_sub;
  logic signed [32:0] add_sum;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !ovalid_r || out_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;

  always_comb begin
    mul_full = mul_a * mul_b;
    mul_rnd  = mul_full + (64'sd1 <<< (Q_FRAC - 1));
    mul_shr  = mul_rnd[63:Q_FRAC];
    if (mul_shr > 40'sh007FFFFFFF)
      mul_q = 32'sh7FFFFFFF;
    else if (mul_shr < -40'sh0080000000)
      mul_q = 32'sh80000000;
    else
      mul_q = mul_shr[31:0];
  end

  always_comb begin
    add_sum = add_sub ? ({add_a[31], add_a} - {add_b[31], add_b})
                      : ({add_a[31], add_a} + {add_b[31], add_b});
    if (add_sum[32] != add_sum[31])
      add_q = add_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else
      add_q = add_sum[31:0];
  end

  // operand selection per sequencer step
  always_comb begin
    mul_a   = step_r;
    mul_b   = sigma_r;
    add_a   = pos_y_r;
    add_b   = pos_x_r;
    add_sub = 1'b1;
    unique case (state_r)
      ST_HS: begin                       // h*sigma ; y-x
        mul_a = step_r;  mul_b = sigma_r;
        add_a = pos_y_r; add_b = pos_x_r; add_sub = 1'b1;
      end
      ST_P1: begin                       // hs*(y-x) ; rho-z
        mul_a = prod_r;  mul_b = d1_r;
        add_a = rho_r;   add_b = pos_z_r; add_sub = 1'b1;
      end
      ST_XD: begin                       // x*(rho-z) ; x+p1
        mul_a = pos_x_r; mul_b = d2_r;
        add_a = pos_x_r; add_b = prod_r;  add_sub = 1'b0;
      end
      ST_XY: begin                       // x*y ; x*(rho-z)-y
        mul_a = pos_x_r; mul_b = pos_y_r;
        add_a = prod_r;  add_b = pos_y_r; add_sub = 1'b1;
      end
      ST_P2: begin                       // h*t1
        mul_a = step_r;  mul_b = d1_r;
      end
      ST_BZ: begin                       // beta*z ; y+p2
        mul_a = beta_r;  mul_b = pos_z_r;
        add_a = pos_y_r; add_b = prod_r;  add_sub = 1'b0;
      end
      ST_T2: begin                       // x*y - beta*z
        add_a = d2_r;    add_b = prod_r;  add_sub = 1'b1;
      end
      ST_P3: begin                       // h*t2
        mul_a = step_r;  mul_b = d1_r;
      end
      ST_DONE: begin                     // z+p3
        add_a = pos_z_r; add_b = prod_r;  add_sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_HS;
      ST_HS:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_XD;
      ST_XD:   state_nxt = ST_XY;
      ST_XY:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_BZ;
      ST_BZ:   state_nxt = ST_T2;
      ST_T2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, configuration and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      step_r   <= RST_STEP_SIZE;
      sigma_r  <= RST_SIGMA;
      rho_r    <= RST_RHO;
      beta_r   <= RST_BETA;
      sx_r     <= RST_START_X;
      sy_r     <= RST_START_Y;
      sz_r     <= RST_START_Z;
      pos_x_r  <= RST_START_X;
      pos_y_r  <= RST_START_Y;
      pos_z_r  <= RST_START_Z;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_STEP_SIZE: step_r  <= cfg_data;
          REG_SIGMA:     sigma_r <= cfg_data;
          REG_RHO:       rho_r   <= cfg_data;
          REG_BETA:      beta_r  <= cfg_data;
          REG_START_X:   sx_r    <= cfg_data;
          REG_START_Y:   sy_r    <= cfg_data;
          REG_START_Z:   sz_r    <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && in_ch.restart) begin
        pos_x_r <= sx_r;
        pos_y_r <= sy_r;
        pos_z_r <= sz_r;
      end
      if (state_r == ST_DONE && out_free) begin
        pos_x_r  <= nx_r;
        pos_y_r  <= ny_r;
        pos_z_r  <= add_q;
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // datapath scratch and output payload
  always_ff @(posedge clk) begin
    if (state_r != ST_DONE && state_r != ST_IDLE)
      prod_r <= mul_q;
    unique case (state_r)
      ST_HS, ST_XY, ST_T2: d1_r <= add_q;
      ST_P1:               d2_r <= add_q;
      ST_P2:               d2_r <= prod_r;   // hold x*y
      ST_XD:               nx_r <= add_q;
      ST_BZ:               ny_r <= add_q;
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) begin
      ox_r <= nx_r;
      oy_r <= ny_r;
      oz_r <= add_q;
    end
  end

endmodule

@@ test/lorenz_euler_integrator_unit_test.sv @@
// testbench of the lorenz euler integrator: directed and random ticks checked against a predictor
`timescale 1ns / 1ps
module lorenz_euler_integrator_unit_test;
  import lei_pkg::*;

  // saturation limits of a Q8.24 value
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;
  // index with no register behind it, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // cycles without any transaction before the run is called hung
  localparam int STALL_LIMIT = 4000;
  // pause after the last result before touching the registers
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES = 7;
  localparam int PHASE_TICKS = 105;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } xyz_t;

  // keeps a private copy of the registers and of the position, steps it for
  // every accepted tick and holds the positions still to come out
  class lorenz_scoreboard;
    q_t h, sig, rho_c, beta_c, sx, sy, sz;
    q_t px, py, pz;
    xyz_t expected[$];
    int errors;
    int checked;

    function new();
      h = RST_STEP_SIZE;
      sig = RST_SIGMA;
      rho_c = RST_RHO;
      beta_c = RST_BETA;
      sx = RST_START_X;
      sy = RST_START_Y;
      sz = RST_START_Z;
      px = RST_START_X;
      py = RST_START_Y;
      pz = RST_START_Z;
      errors = 0;
      checked = 0;
    endfunction

    function q_t sat32(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return q_t'(v[31:0]);
    endfunction

    // product rounded half up back to Q8.24, the shift floors
    function q_t qmul(q_t a, q_t b);
      longint p;
      p = longint'(a) * longint'(b) + (64'sd1 <<< (Q_FRAC - 1));
      return sat32(p >>> Q_FRAC);
    endfunction

    function q_t qadd(q_t a, q_t b);
      return sat32(longint'(a) + longint'(b));
    endfunction

    function q_t qsub(q_t a, q_t b);
      return sat32(longint'(a) - longint'(b));
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, q_t v);
      case (idx)
        REG_STEP_SIZE: h = v;
        REG_SIGMA:     sig = v;
        REG_RHO:       rho_c = v;
        REG_BETA:      beta_c = v;
        REG_START_X:   sx = v;
        REG_START_Y:   sy = v;
        REG_START_Z:   sz = v;
        default: ;
      endcase
    endfunction

    // one euler step: x' = x + h*sigma*(y-x), y' = y + h*(x*(rho-z)-y),
    // z' = z + h*(x*y - beta*z)
    function void note_tick(bit restart);
      q_t hs;
      xyz_t n;
      if (restart) begin
        px = sx;
        py = sy;
        pz = sz;
      end
      hs = qmul(h, sig);
      n.x = qadd(px, qmul(hs, qsub(py, px)));
      n.y = qadd(py, qmul(h, qsub(qmul(px, qsub(rho_c, pz)), py)));
      n.z = qadd(pz, qmul(h, qsub(qmul(px, py), qmul(beta_c, pz))));
      px = n.x;
      py = n.y;
      pz = n.z;
      expected.push_back(n);
    endfunction

    function int pending();
      return expected.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_result(q_t x, q_t y, q_t z);
      xyz_t e;
      checked++;
      if (expected.size() == 0) begin
        report($sformatf("result %h %h %h with no tick pending", x, y, z));
        return;
      end
      e = expected.pop_front();
      if (x !== e.x) report($sformatf("result %0d out_x %h, want %h", checked, x, e.x));
      if (y !== e.y) report($sformatf("result %0d out_y %h, want %h", checked, y, e.y));
      if (z !== e.z) report($sformatf("result %0d out_z %h, want %h", checked, z, e.z));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [QW-1:0]        cfg_data;

  lei_in_if  in_ch ();
  lei_out_if out_ch ();

  lorenz_scoreboard board = new();

  // both sides skip their random gaps while this is set
  bit steady_mode = 1'b0;
  int ticks_sent = 0;
  int restarts_sent = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  lorenz_euler_integrator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one tick and hold it until the block takes it; called and
  // returning at a rising edge so that valid can stay high across ticks
  task automatic send_tick(bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    board.note_tick(restart);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  // stop offering and let every pending result drain before a register write
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, q_t v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    board.write_reg(idx, v);
  endtask

  task automatic load_config(q_t h, q_t s, q_t r, q_t b, q_t x, q_t y, q_t z,
                             bit poke_unused);
    write_reg(REG_STEP_SIZE, h);
    write_reg(REG_SIGMA, s);
    write_reg(REG_RHO, r);
    write_reg(REG_BETA, b);
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
    if (poke_unused) write_reg(REG_UNUSED, q_t'($urandom));
    write_reg(REG_START_Z, z);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // plausible lorenz values keep the orbit alive; wild ones drive saturation
  function automatic q_t pick_reg(logic [CFG_IDX_W-1:0] idx, bit wild);
    if (wild) begin
      case ($urandom_range(0, 3))
        0: return Q_MAX;
        1: return Q_MIN;
        default: return q_t'($urandom);
      endcase
    end
    case (idx)
      REG_STEP_SIZE: return q_t'($urandom_range(1, 1 << 19));
      REG_SIGMA:     return q_t'($urandom_range(0, 20 << 24));
      REG_RHO:       return q_t'($urandom_range(0, 50 << 24));
      REG_BETA:      return q_t'($urandom_range(0, 5 << 24));
      default:       return q_t'(int'($urandom_range(0, 40 << 24)) - (20 << 24));
    endcase
  endfunction

  // result side: check every accepted result, stall at random, and once
  // hold off long enough that the block backs up and drops in_ch.ready
  initial begin : result_sink
    int hold;
    bit long_hold_done;
    hold = 0;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result(q_t'(out_ch.out_x), q_t'(out_ch.out_y), q_t'(out_ch.out_z));
      if (!long_hold_done && board.checked >= 250) begin
        hold = 300;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_mode && $urandom_range(0, 5) == 0) hold = pick_gap();
      end
    end
  end

  // hang detection: any transaction on either side clears the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    q_t v [7];
    bit wild;
    bit restart;
    in_ch.valid <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_STEP_SIZE;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset values: plain steps from the reset point, then restart held
    // high so the same step repeats, then plain steps again
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // a write to the unused index must change nothing
    settle();
    write_reg(REG_UNUSED, Q_MIN);
    write_reg(REG_UNUSED, q_t'(-1));
    cfg_we <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);

    // register extremes in both directions drive products and sums into saturation
    settle();
    load_config(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
    load_config(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    // all zero: the state freezes at the origin
    settle();
    load_config('0, '0, '0, '0, '0, '0, '0, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // back to the stock coefficients
    settle();
    load_config(RST_STEP_SIZE, RST_SIGMA, RST_RHO, RST_BETA, RST_START_X, RST_START_Y,
                RST_START_Z, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // random phases: mostly plausible orbits with rare restarts, two phases
    // with wild registers, one without any gaps on either side
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      wild = (ph == 3 || ph == 5);
      steady_mode = (ph == 2);
      for (int i = 0; i < 7; i++)
        v[i] = pick_reg(i[CFG_IDX_W-1:0], wild && $urandom_range(0, 1));
      load_config(v[0], v[1], v[2], v[3], v[4], v[5], v[6], 1'($urandom_range(0, 1)));
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (k == 0) restart = 1'($urandom_range(0, 1));
        else if (ph == 4 && k >= 40 && k < 46) restart = 1'b1;
        else restart = ($urandom_range(0, 24) == 0);
        send_tick(restart);
      end
    end
    steady_mode = 1'b0;

    // drain, then a quiet tail in case anything stray comes out
    in_ch.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.pending() > 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("run covered %0d ticks (%0d with restart) over %0d register settings",
             ticks_sent, restarts_sent, settings_used);
    $display("%0d results checked, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ lorenz_euler_integrator_unit.f @@
rtl/lei_pkg.sv
rtl/lei_if.sv
rtl/lorenz_euler_integrator_unit.sv
test/lorenz_euler_integrator_unit_test.sv
